>>> rtl/daq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daq_pkg
// Types and constants shared by the drowsiness alert qualifier modules.
// ----------------------------------------------------------------------------
package daq_pkg;

  localparam int unsigned CntW     = 8;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CntW-1:0] CntMax = '1;

  // reset values of the configuration registers
  localparam logic [CntW-1:0]   LowOnReset      = 8'd10;
  localparam logic [CntW-1:0]   LowOffReset     = 8'd5;
  localparam logic [CntW-1:0]   HighOnReset     = 8'd20;
  localparam logic [TimerW-1:0] LowTimeoutReset = 16'd5000;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOW_ON      = 2'd0,
    REG_LOW_OFF     = 2'd1,
    REG_HIGH_ON     = 2'd2,
    REG_LOW_TIMEOUT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CntW-1:0]   low_on_count;
    logic [CntW-1:0]   low_off_count;
    logic [CntW-1:0]   high_on_count;
    logic [TimerW-1:0] low_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              left_eye_closed;
    logic              right_eye_closed;
    logic              mouth_open;
    logic [LevelW-1:0] score;
  } item_t;

  typedef struct packed {
    logic              low_alert;
    logic              high_alert;
    logic              low_alert_changed;
    logic              high_alert_changed;
    logic [LevelW-1:0] drowsy_level;
  } result_t;

endpackage

>>> rtl/daq_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daq_cfg_regs
// Threshold and timeout registers, written through a plain write port.
// ----------------------------------------------------------------------------
module daq_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [daq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [daq_pkg::CfgDataW-1:0]  cfg_data_i,
  output daq_pkg::cfg_t                 cfg_o
);

  daq_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (daq_pkg::reg_idx_e'(cfg_index_i))
        daq_pkg::REG_LOW_ON:
          cfg_d.low_on_count = cfg_data_i[daq_pkg::CntW-1:0];
        daq_pkg::REG_LOW_OFF:
          cfg_d.low_off_count = cfg_data_i[daq_pkg::CntW-1:0];
        daq_pkg::REG_HIGH_ON:
          cfg_d.high_on_count = cfg_data_i[daq_pkg::CntW-1:0];
        daq_pkg::REG_LOW_TIMEOUT:
          cfg_d.low_timeout_ticks = cfg_data_i[daq_pkg::TimerW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_on_count      <= daq_pkg::LowOnReset;
      cfg_q.low_off_count     <= daq_pkg::LowOffReset;
      cfg_q.high_on_count     <= daq_pkg::HighOnReset;
      cfg_q.low_timeout_ticks <= daq_pkg::LowTimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/daq_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daq_engine
// Alert state and its one-pass update for a frame, tick or clear item.
// ----------------------------------------------------------------------------
module daq_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  daq_pkg::item_t   item_i,
  input  daq_pkg::cfg_t    cfg_i,
  output daq_pkg::result_t res_o
);

  logic [daq_pkg::CntW-1:0]   low_cnt_q, low_cnt_d;
  logic [daq_pkg::CntW-1:0]   high_cnt_q, high_cnt_d;
  logic                       low_active_q, low_active_d;
  logic                       high_active_q, high_active_d;
  logic [daq_pkg::TimerW-1:0] timeout_q, timeout_d;
  logic [daq_pkg::LevelW-1:0] level_q, level_d;

  logic                       eyes, suspect;
  logic [daq_pkg::CntW-1:0]   low_inc, high_inc;
  logic                       rise;
  logic                       low_mid;
  logic [daq_pkg::TimerW-1:0] timeout_mid;
  logic [daq_pkg::TimerW-1:0] timeout_dec;

  assign eyes     = item_i.left_eye_closed & item_i.right_eye_closed;
  assign suspect  = eyes | item_i.mouth_open;
  assign low_inc  = (low_cnt_q == daq_pkg::CntMax) ? low_cnt_q : low_cnt_q + 1'b1;
  assign high_inc = (high_cnt_q == daq_pkg::CntMax) ? high_cnt_q : high_cnt_q + 1'b1;
  assign timeout_dec = timeout_q - 1'b1;

  always_comb begin
    low_cnt_d     = low_cnt_q;
    high_cnt_d    = high_cnt_q;
    low_active_d  = low_active_q;
    high_active_d = high_active_q;
    timeout_d     = timeout_q;
    level_d       = level_q;
    rise          = 1'b0;
    low_mid       = low_active_q;
    timeout_mid   = timeout_q;

    case (daq_pkg::cmd_e'(item_i.cmd))
      daq_pkg::CMD_FRAME: begin
        level_d   = item_i.score;
        low_cnt_d = suspect ? low_inc : '0;
        rise = (low_cnt_d >= cfg_i.low_on_count) && !low_active_q && !high_active_q;
        low_mid     = low_active_q | rise;
        timeout_mid = rise ? cfg_i.low_timeout_ticks : timeout_q;
        low_active_d = low_mid;
        timeout_d    = timeout_mid;
        // off rule also catches a frame that raised the alert just now
        if (low_mid && (low_cnt_d < cfg_i.low_off_count)) begin
          low_active_d = 1'b0;
          low_cnt_d    = '0;
          timeout_d    = '0;
        end
        high_cnt_d = eyes ? high_inc : '0;
        if (high_cnt_d >= cfg_i.high_on_count) begin
          high_active_d = 1'b1;
        end
      end
      daq_pkg::CMD_TICK: begin
        if (timeout_q != '0) begin
          timeout_d = timeout_dec;
          if (timeout_dec == '0) begin
            low_active_d = 1'b0;
            low_cnt_d    = '0;
          end
        end
      end
      daq_pkg::CMD_CLEAR: begin
        if (high_active_q) begin
          high_active_d = 1'b0;
          high_cnt_d    = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_cnt_q     <= '0;
      high_cnt_q    <= '0;
      low_active_q  <= 1'b0;
      high_active_q <= 1'b0;
      timeout_q     <= '0;
      level_q       <= '0;
    end else if (step_i) begin
      low_cnt_q     <= low_cnt_d;
      high_cnt_q    <= high_cnt_d;
      low_active_q  <= low_active_d;
      high_active_q <= high_active_d;
      timeout_q     <= timeout_d;
      level_q       <= level_d;
    end
  end

  assign res_o.low_alert          = low_active_d;
  assign res_o.high_alert         = high_active_d;
  assign res_o.low_alert_changed  = low_active_d ^ low_active_q;
  assign res_o.high_alert_changed = high_active_d ^ high_active_q;
  assign res_o.drowsy_level       = level_d;

  // a running timer always belongs to an active low alert
  a_timer_needs_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timeout_q != '0) |-> low_active_q)
    else $error("timer running without low alert");

  // the high alert is only set by a frame
  a_high_rise_on_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(high_active_q) |-> $past(step_i && (item_i.cmd == daq_pkg::CMD_FRAME)))
    else $error("high alert set by a non-frame item");

  // state holds when no item advances
  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(low_active_q) && $stable(high_active_q) &&
                 $stable(timeout_q) && $stable(low_cnt_q) && $stable(high_cnt_q)))
    else $error("alert state moved without an item");

endmodule

>>> rtl/drowsiness_alert_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drowsiness_alert_qualifier
// Qualifies eye and mouth detections into a low and a latched high alert.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  in        in_valid_i / in_ready_o     cmd, eye flags, mouth_open, score
//  out       out_valid_o / out_ready_i   alerts, changed flags, drowsy_level
//  cfg       cfg_we_i                    cfg_index_i, cfg_data_i
//
//  One item per cycle sustained while the output is not stalled. An accepted
//  item waits in the input register until its result is registered.
//  The state update for an item is one pass of compare and increment logic.
//  Reset clears all alert state and loads the register defaults.
//  A stalled output holds its result; the input register still takes one
//  more item, after which in_ready_o drops until the output drains.
// ----------------------------------------------------------------------------
module drowsiness_alert_qualifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [daq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [daq_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic                          left_eye_closed_i,
  input  logic                          right_eye_closed_i,
  input  logic                          mouth_open_i,
  input  logic [daq_pkg::LevelW-1:0]    score_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          low_alert_o,
  output logic                          high_alert_o,
  output logic                          low_alert_changed_o,
  output logic                          high_alert_changed_o,
  output logic [daq_pkg::LevelW-1:0]    drowsy_level_o
);

  daq_pkg::cfg_t    cfg;
  daq_pkg::item_t   item_q;
  daq_pkg::result_t res, res_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             step;

  daq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // item moves from the input register into the result register
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.cmd              <= cmd_i;
      item_q.left_eye_closed  <= left_eye_closed_i;
      item_q.right_eye_closed <= right_eye_closed_i;
      item_q.mouth_open       <= mouth_open_i;
      item_q.score            <= score_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  daq_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o          = out_valid_q;
  assign low_alert_o          = res_q.low_alert;
  assign high_alert_o         = res_q.high_alert;
  assign low_alert_changed_o  = res_q.low_alert_changed;
  assign high_alert_changed_o = res_q.high_alert_changed;
  assign drowsy_level_o       = res_q.drowsy_level;

endmodule

>>> bench/drowsiness_alert_qualifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drowsiness_alert_qualifier_tb
// Self-checking bench for the alert qualifier. A short directed list runs
// first, then random frames, ticks, clears and unused commands under several
// register settings. Each returned status is compared with a cycle-free alert
// model kept inside the bench, or with the expected status of a typed row.
// ----------------------------------------------------------------------------
module drowsiness_alert_qualifier_tb;

  localparam logic [1:0]  CmdUnused     = 2'd3;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldOffCycles = 200;
  localparam int          PredictLevel  = -1;

  typedef enum int unsigned {
    RUN_EYES,
    RUN_YAWN,
    RUN_NOISE
  } run_kind_e;

  typedef struct packed {
    logic                         is_reg;
    daq_pkg::reg_idx_e            reg_idx;
    logic [daq_pkg::CfgDataW-1:0] reg_val;
    daq_pkg::item_t               it;
    logic                         typed;
    daq_pkg::result_t             want;
  } dir_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [daq_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [daq_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [1:0]                   cmd_i = '0;
  logic                         left_eye_closed_i = 1'b0;
  logic                         right_eye_closed_i = 1'b0;
  logic                         mouth_open_i = 1'b0;
  logic [daq_pkg::LevelW-1:0]   score_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic                         low_alert_o;
  logic                         high_alert_o;
  logic                         low_alert_changed_o;
  logic                         high_alert_changed_o;
  logic [daq_pkg::LevelW-1:0]   drowsy_level_o;

  drowsiness_alert_qualifier u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .cmd_i                (cmd_i),
    .left_eye_closed_i    (left_eye_closed_i),
    .right_eye_closed_i   (right_eye_closed_i),
    .mouth_open_i         (mouth_open_i),
    .score_i              (score_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .low_alert_o          (low_alert_o),
    .high_alert_o         (high_alert_o),
    .low_alert_changed_o  (low_alert_changed_o),
    .high_alert_changed_o (high_alert_changed_o),
    .drowsy_level_o       (drowsy_level_o)
  );

  always #5 clk_i = ~clk_i;

  // alert model state and its copy of the registers
  daq_pkg::cfg_t                model_cfg;
  logic [daq_pkg::CntW-1:0]     low_run;
  logic [daq_pkg::CntW-1:0]     high_run;
  logic                         low_on;
  logic                         high_on;
  logic [daq_pkg::TimerW-1:0]   ticks_left;
  logic [daq_pkg::LevelW-1:0]   level_q;

  daq_pkg::result_t alert_status_q[$];
  dir_row_t         directed_rows[$];
  int unsigned      error_count = 0;
  int unsigned      idle_cycles = 0;
  logic             gaps_on = 1'b1;
  logic             hold_off_req = 1'b0;

  // random stream shaping
  int unsigned seg_left = 0;
  run_kind_e   seg_kind = RUN_NOISE;
  int unsigned seg_max = 20;
  int unsigned eyes_pct = 40;
  int unsigned clear_pct = 4;

  function automatic logic [daq_pkg::CntW-1:0] bump_run(input logic [daq_pkg::CntW-1:0] v);
    return (v == daq_pkg::CntMax) ? v : v + 1'b1;
  endfunction

  function automatic void end_low_alert();
    low_on     = 1'b0;
    low_run    = '0;
    ticks_left = '0;
  endfunction

  function automatic daq_pkg::result_t step_alerts(input daq_pkg::item_t it);
    logic             low_was;
    logic             high_was;
    logic             eyes;
    daq_pkg::result_t r;
    low_was  = low_on;
    high_was = high_on;
    eyes     = it.left_eye_closed && it.right_eye_closed;
    case (it.cmd)
      daq_pkg::CMD_FRAME: begin
        level_q = it.score;
        low_run = (eyes || it.mouth_open) ? bump_run(low_run) : '0;
        if (low_run >= model_cfg.low_on_count && !low_on && !high_on) begin
          low_on     = 1'b1;
          ticks_left = model_cfg.low_timeout_ticks;
        end
        // off rule may undo a rise on the same frame
        if (low_run < model_cfg.low_off_count && low_on) end_low_alert();
        high_run = eyes ? bump_run(high_run) : '0;
        if (high_run >= model_cfg.high_on_count) high_on = 1'b1;
      end
      daq_pkg::CMD_TICK: begin
        if (ticks_left != '0) begin
          ticks_left = ticks_left - 1'b1;
          if (ticks_left == '0) end_low_alert();
        end
      end
      daq_pkg::CMD_CLEAR: begin
        if (high_on) begin
          high_on  = 1'b0;
          high_run = '0;
        end
      end
      default: ;
    endcase
    r.low_alert          = low_on;
    r.high_alert         = high_on;
    r.low_alert_changed  = low_on != low_was;
    r.high_alert_changed = high_on != high_was;
    r.drowsy_level       = level_q;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic daq_pkg::item_t gen_item();
    daq_pkg::item_t it;
    int unsigned    roll;
    it.left_eye_closed  = 1'($urandom_range(1));
    it.right_eye_closed = 1'($urandom_range(1));
    it.mouth_open       = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) it.score = $urandom_range(1) ? 8'hFF : 8'h00;
    else it.score = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 4) begin
      it.cmd = CmdUnused;
    end else if (roll < 4 + clear_pct) begin
      it.cmd = daq_pkg::CMD_CLEAR;
    end else if (roll < 22 + clear_pct) begin
      it.cmd = daq_pkg::CMD_TICK;
    end else begin
      it.cmd = daq_pkg::CMD_FRAME;
      if (seg_left == 0) begin
        seg_left = $urandom_range(seg_max, 1);
        roll = $urandom_range(99);
        if (roll < eyes_pct) seg_kind = RUN_EYES;
        else if (roll < eyes_pct + (100 - eyes_pct) / 2) seg_kind = RUN_YAWN;
        else seg_kind = RUN_NOISE;
      end
      seg_left--;
      case (seg_kind)
        RUN_EYES: begin
          it.left_eye_closed  = 1'b1;
          it.right_eye_closed = 1'b1;
        end
        RUN_YAWN: begin
          it.mouth_open = 1'b1;
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  function automatic dir_row_t item_row(input logic [1:0] cmd, input logic l, input logic r,
                                        input logic m, input logic [7:0] score,
                                        input int level);
    dir_row_t row;
    row       = '0;
    row.it    = {cmd, l, r, m, score};
    row.typed = level != PredictLevel;
    // typed rows only cover states with both alerts quiet
    row.want  = {4'b0000, 8'(level)};
    return row;
  endfunction

  function automatic dir_row_t reg_row(input daq_pkg::reg_idx_e idx,
                                       input logic [daq_pkg::CfgDataW-1:0] val);
    dir_row_t row;
    row         = '0;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input daq_pkg::item_t it, input logic typed,
                           input daq_pkg::result_t want);
    int unsigned      gap;
    daq_pkg::result_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         = 1'b1;
    cmd_i              = it.cmd;
    left_eye_closed_i  = it.left_eye_closed;
    right_eye_closed_i = it.right_eye_closed;
    mouth_open_i       = it.mouth_open;
    score_i            = it.score;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = step_alerts(it);
    alert_status_q.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (alert_status_q.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input daq_pkg::reg_idx_e idx,
                           input logic [daq_pkg::CfgDataW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      daq_pkg::REG_LOW_ON:      model_cfg.low_on_count      = val[daq_pkg::CntW-1:0];
      daq_pkg::REG_LOW_OFF:     model_cfg.low_off_count     = val[daq_pkg::CntW-1:0];
      daq_pkg::REG_HIGH_ON:     model_cfg.high_on_count     = val[daq_pkg::CntW-1:0];
      daq_pkg::REG_LOW_TIMEOUT: model_cfg.low_timeout_ticks = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [7:0] on_cnt, input logic [7:0] off_cnt,
                           input logic [7:0] high_cnt, input logic [15:0] timeout,
                           input int unsigned n_items, input logic idle, input logic hold,
                           input int unsigned run_max, input int unsigned eye_mix,
                           input int unsigned clr_mix);
    int unsigned    sent;
    daq_pkg::item_t it;
    wait_idle();
    write_reg(daq_pkg::REG_LOW_ON, {8'h00, on_cnt});
    write_reg(daq_pkg::REG_LOW_OFF, {8'h00, off_cnt});
    write_reg(daq_pkg::REG_HIGH_ON, {8'h00, high_cnt});
    write_reg(daq_pkg::REG_LOW_TIMEOUT, timeout);
    gaps_on   = idle;
    seg_max   = run_max;
    eyes_pct  = eye_mix;
    clear_pct = clr_mix;
    seg_left  = 0;
    if (hold) hold_off_req = 1'b1;
    sent = 0;
    while (sent < n_items) begin
      it = gen_item();
      send_item(it, 1'b0, '0);
      if (it.cmd != CmdUnused) sent++;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    daq_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (alert_status_q.size() == 0) begin
        $display("%0t: status item with nothing expected, actual %b%b%b%b %0d", $time,
                 low_alert_o, high_alert_o, low_alert_changed_o, high_alert_changed_o,
                 drowsy_level_o);
        error_count++;
      end else begin
        want = alert_status_q.pop_front();
        check_field("low_alert", want.low_alert, low_alert_o);
        check_field("high_alert", want.high_alert, high_alert_o);
        check_field("low_alert_changed", want.low_alert_changed, low_alert_changed_o);
        check_field("high_alert_changed", want.high_alert_changed, high_alert_changed_o);
        check_field("drowsy_level", want.drowsy_level, drowsy_level_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // status sink: random stalls, one long hold-off on request
  initial begin : status_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i  = 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          out_ready_i = 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      out_ready_i = 1'b1;
    end
  end

  initial begin
    model_cfg  = {daq_pkg::LowOnReset, daq_pkg::LowOffReset, daq_pkg::HighOnReset,
                  daq_pkg::LowTimeoutReset};
    low_run    = '0;
    high_run   = '0;
    low_on     = 1'b0;
    high_on    = 1'b0;
    ticks_left = '0;
    level_q    = '0;

    // quiet state after reset, unused command, score extremes
    directed_rows.push_back(item_row(daq_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0, 8'h00, 0));
    directed_rows.push_back(item_row(daq_pkg::CMD_CLEAR, 1'b1, 1'b1, 1'b1, 8'hFF, 0));
    directed_rows.push_back(item_row(CmdUnused, 1'b1, 1'b1, 1'b1, 8'hFF, 0));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b0, 1'b0, 1'b0, 8'hFF, 255));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b0, 1'b0, 1'b0, 8'h00, 0));
    // short thresholds: rise, timeout, latch, clear, off rule
    directed_rows.push_back(reg_row(daq_pkg::REG_LOW_ON, 16'd2));
    directed_rows.push_back(reg_row(daq_pkg::REG_LOW_OFF, 16'd1));
    directed_rows.push_back(reg_row(daq_pkg::REG_HIGH_ON, 16'd3));
    directed_rows.push_back(reg_row(daq_pkg::REG_LOW_TIMEOUT, 16'd2));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b1, 1'b1, 1'b0, 8'h5A,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b1, 1'b1, 1'b0, 8'hA5,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0, 8'h00,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b0, 1'b0, 1'b1, 8'h33,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_TICK, 1'b1, 1'b1, 1'b1, 8'hFF,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b1, 1'b0, 1'b0, 8'h01,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b1, 1'b1, 1'b0, 8'h10,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b1, 1'b1, 1'b0, 8'h20,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b1, 1'b1, 1'b1, 8'h30,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_CLEAR, 1'b0, 1'b0, 1'b0, 8'h00,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b0, 1'b1, 1'b0, 8'hFE,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0, 8'h00,
                                     PredictLevel));
    // off above on: rise and fall on one frame; timer disabled
    directed_rows.push_back(reg_row(daq_pkg::REG_LOW_ON, 16'd1));
    directed_rows.push_back(reg_row(daq_pkg::REG_LOW_OFF, 16'd3));
    directed_rows.push_back(reg_row(daq_pkg::REG_LOW_TIMEOUT, 16'd0));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b0, 1'b0, 1'b1, 8'h77,
                                     PredictLevel));
    // zero thresholds compare as written
    directed_rows.push_back(reg_row(daq_pkg::REG_LOW_ON, 16'd0));
    directed_rows.push_back(reg_row(daq_pkg::REG_LOW_OFF, 16'd0));
    directed_rows.push_back(reg_row(daq_pkg::REG_HIGH_ON, 16'd0));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b0, 1'b0, 1'b0, 8'h42,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0, 8'h00,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_CLEAR, 1'b0, 1'b0, 1'b0, 8'h00,
                                     PredictLevel));
    directed_rows.push_back(item_row(daq_pkg::CMD_FRAME, 1'b0, 1'b1, 1'b0, 8'h99,
                                     PredictLevel));

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    run_phase(8'd10, 8'd5, 8'd20, 16'd5000, 150, 1'b1, 1'b0, 44, 40, 4);
    run_phase(8'd3, 8'd2, 8'd6, 16'd4, 200, 1'b0, 1'b0, 12, 40, 4);
    // long closed-eye runs drive both counters into saturation
    run_phase(8'd255, 8'd255, 8'd255, 16'd65535, 350, 1'b1, 1'b0, 300, 85, 1);
    run_phase(8'd1, 8'd200, 8'd2, 16'd1, 150, 1'b1, 1'b1, 6, 40, 6);
    run_phase(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
              8'($urandom_range(255, 1)), 16'($urandom_range(30, 1)), 75, 1'b1, 1'b0,
              40, 50, 4);
    run_phase(8'($urandom_range(12, 1)), 8'($urandom_range(12, 1)),
              8'($urandom_range(16, 1)), 16'($urandom_range(65535, 1)), 75, 1'b1, 1'b0,
              20, 40, 4);

    in_valid_i = 1'b0;
    while (alert_status_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/daq_pkg.sv
rtl/daq_cfg_regs.sv
rtl/daq_engine.sv
rtl/drowsiness_alert_qualifier.sv
bench/drowsiness_alert_qualifier_tb.sv
